// ----- rtl/core/kbeq_pkg.sv -----
// ---------------------------------------------------------------------------
// kbeq_pkg: shared types and constants of the keyboard event queue poster
// Holds the operation and command codes, the scan ROM, the record layout
// and the descriptor that travels from the front end to the back end.
// ---------------------------------------------------------------------------
package kbeq_pkg;

   // Input operations
   localparam logic [1:0] OP_COMMAND  = 2'd0;
   localparam logic [1:0] OP_KEY_DOWN = 2'd1;
   localparam logic [1:0] OP_KEY_UP   = 2'd2;
   localparam logic [1:0] OP_KEY_AUTO = 2'd3;

   // Keyboard commands and their replies
   localparam logic [7:0] CMD_INQUIRY   = 8'h10;
   localparam logic [7:0] CMD_INSTANT   = 8'h14;
   localparam logic [7:0] CMD_MODEL     = 8'h16;
   localparam logic [7:0] CMD_TEST      = 8'h36;
   localparam logic [7:0] REPLY_KEY     = 8'h7B;
   localparam logic [7:0] REPLY_TEST    = 8'h7D;
   localparam logic [7:0] REPLY_MODEL   = 8'h0B;
   localparam logic [7:0] REPLY_NONE    = 8'h00;

   // Configuration register indexes
   localparam logic [1:0] CSR_BUFFER_BASE = 2'd0;
   localparam logic [1:0] CSR_QUEUE_SLOTS = 2'd1;
   localparam logic [1:0] CSR_PASSTHROUGH = 2'd2;

   // Result kinds
   localparam logic RESULT_REPLY = 1'b0;
   localparam logic RESULT_WRITE = 1'b1;

   // Record layout and system pointers
   localparam logic [31:0] RECORD_SIZE   = 32'd22;
   localparam logic [31:0] HEAD_PTR_ADDR = 32'h0000_014C;
   localparam logic [31:0] TAIL_PTR_ADDR = 32'h0000_0150;
   localparam logic [15:0] EVENT_TYPE    = 16'h0004;
   localparam logic [15:0] SHIFT_MOD     = 16'h0200;
   localparam logic [31:0] OFS_TYPE      = 32'd4;
   localparam logic [31:0] OFS_KIND      = 32'd6;
   localparam logic [31:0] OFS_MSG       = 32'd8;
   localparam logic [31:0] OFS_TICKS     = 32'd12;
   localparam logic [31:0] OFS_WHERE     = 32'd16;
   localparam logic [31:0] OFS_MODS      = 32'd20;

   // Back end write sequence
   localparam int unsigned SEQ_STEPS  = 9;
   localparam int unsigned STEP_W     = $clog2(SEQ_STEPS);
   localparam logic [STEP_W-1:0] STEP_LINK  = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_TAIL  = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_NEXT  = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_TYPE  = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_KIND  = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_MSG   = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_TICKS = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_WHERE = STEP_W'(7);
   localparam logic [STEP_W-1:0] STEP_MODS  = STEP_W'(8);

   // Descriptor queue between front and back
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Scan ROM, indexed by the 7-bit character
   localparam int unsigned SCAN_TABLE_ENTRIES = 128;
   localparam logic [7:0] SCAN_ROM [0:SCAN_TABLE_ENTRIES-1] = '{
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'h33, 8'h30, 8'hFF, 8'hFF, 8'hFF, 8'h49, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h46, 8'h42, 8'h4D, 8'h48,
      8'h31, 8'h92, 8'hA7, 8'h94, 8'h95, 8'h97, 8'h9A, 8'h27,
      8'h99, 8'h9D, 8'h9C, 8'h98, 8'h2B, 8'h1B, 8'h2F, 8'h2C,
      8'h1D, 8'h12, 8'h13, 8'h14, 8'h15, 8'h17, 8'h16, 8'h1A,
      8'h1C, 8'h19, 8'hA9, 8'h29, 8'hAB, 8'h18, 8'hAF, 8'hAC,
      8'h93, 8'h80, 8'h8B, 8'h88, 8'h82, 8'h8E, 8'h83, 8'h85,
      8'h84, 8'hA2, 8'hA6, 8'hA8, 8'hA5, 8'hAE, 8'hAD, 8'h9F,
      8'hA3, 8'h8C, 8'h8F, 8'h81, 8'h91, 8'hA0, 8'h89, 8'h8D,
      8'h87, 8'h90, 8'h86, 8'hFF, 8'h2A, 8'hFF, 8'h96, 8'h9B,
      8'h32, 8'h00, 8'h0B, 8'h08, 8'h02, 8'h0E, 8'h03, 8'h05,
      8'h04, 8'h22, 8'h26, 8'h28, 8'h25, 8'h2E, 8'h2D, 8'h1F,
      8'h23, 8'h0C, 8'h0F, 8'h01, 8'h11, 8'h20, 8'h09, 8'h0D,
      8'h07, 8'h10, 8'h06, 8'hFF, 8'hAA, 8'hFF, 8'hB2, 8'hFF
   };

   // One classified item handed to the back end
   typedef struct packed {
      logic        is_cmd;
      logic [7:0]  reply;
      logic [31:0] link_addr;
      logic [31:0] rec;
      logic [2:0]  kind;
      logic [15:0] msg;
      logic [31:0] ticks;
      logic [31:0] where;
      logic [15:0] mods;
   } desc_type;

endpackage

// ----- rtl/core/keyboard_event_queue_poster.sv -----
// ---------------------------------------------------------------------------
// keyboard_event_queue_poster: keyboard command replies and event posting
// Top level joining the classifying front end, the descriptor queue and
// the write sequencer.
// ---------------------------------------------------------------------------
// The front end takes one item per clock while its four-entry descriptor
// queue has room: a command yields one reply result, a key event that
// passes the enable, mask and ring-full checks yields nine memory write
// results, and a dropped event yields none. The back-end sequencer emits
// one result per cycle while no result waits unpopped, so a posted event
// fills the result port with nine results and a command with one.
// Results sit in an output register; a new result is loaded as the
// previous one is popped. The ring limit is registered together with
// buffer_base and queue_slots, so it is current for the first item after
// a configuration write.
module keyboard_event_queue_poster (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_command_byte,
   input  logic [15:0] req_key_value,
   input  logic [4:0]  req_key_modifiers,
   input  logic [15:0] req_event_mask,
   input  logic [31:0] req_queue_head,
   input  logic [31:0] req_queue_tail,
   input  logic [31:0] req_tick_count,
   input  logic [31:0] req_mouse_where,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_reply_byte,
   output logic [31:0] rsp_write_address,
   output logic [31:0] rsp_write_data,
   output logic        rsp_write_long,
   output logic        rsp_last_item
);

   kbeq_pkg::desc_type front_desc;
   kbeq_pkg::desc_type back_desc;
   logic               front_push;
   logic               fifo_full;
   logic               fifo_empty;
   logic               back_pop;
   logic               accept;

   // Input transfer when the descriptor queue has room
   assign full   = fifo_full;
   assign accept = push && !fifo_full;

   kbeq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .accept         (accept),
      .operation      (req_operation),
      .command_byte   (req_command_byte),
      .key_value      (req_key_value),
      .key_modifiers  (req_key_modifiers),
      .event_mask     (req_event_mask),
      .queue_head     (req_queue_head),
      .queue_tail     (req_queue_tail),
      .tick_count     (req_tick_count),
      .mouse_where    (req_mouse_where),
      .desc_push      (front_push),
      .desc           (front_desc)
   );

   kbeq_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_push),
      .wr_data (front_desc),
      .full    (fifo_full),
      .rd_en   (back_pop),
      .rd_data (back_desc),
      .empty   (fifo_empty)
   );

   kbeq_back u_back (
      .clock             (clock),
      .reset             (reset),
      .desc_empty        (fifo_empty),
      .desc              (back_desc),
      .desc_pop          (back_pop),
      .empty             (empty),
      .pop               (pop),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_write_long    (rsp_write_long),
      .rsp_last_item     (rsp_last_item)
   );

endmodule

// ----- rtl/core/kbeq_front.sv -----
// ---------------------------------------------------------------------------
// kbeq_front: accept and classify input items
// Holds the configuration registers and the enable flag, answers commands,
// maps keys by scan ROM or passthrough, decides drops, places the record.
// ---------------------------------------------------------------------------
module kbeq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_write_data,
   input  logic                  accept,
   input  logic [1:0]            operation,
   input  logic [7:0]            command_byte,
   input  logic [15:0]           key_value,
   input  logic [4:0]            key_modifiers,
   input  logic [15:0]           event_mask,
   input  logic [31:0]           queue_head,
   input  logic [31:0]           queue_tail,
   input  logic [31:0]           tick_count,
   input  logic [31:0]           mouse_where,
   output logic                  desc_push,
   output kbeq_pkg::desc_type    desc
);

   logic [31:0] base_ff;
   logic [31:0] base_in;
   logic [15:0] slots_ff;
   logic [15:0] slots_in;
   logic        passthrough_ff;
   logic        passthrough_in;
   logic        enabled_ff;
   logic        enabled_in;
   logic [31:0] limit_ff;
   logic [31:0] limit_in;

   logic [6:0]  ch;
   logic [7:0]  scan;
   logic [2:0]  kind;
   logic [15:0] msg;
   logic [15:0] mods;
   logic [7:0]  reply;
   logic        model_cmd;
   logic        head_zero;
   logic [31:0] next_rec;
   logic [31:0] rec;
   logic        ring_full;
   logic        keep_event;

   assign csr_ready = 1'b1;

   // Next configuration values on a register transfer
   always_comb begin
      base_in        = base_ff;
      slots_in       = slots_ff;
      passthrough_in = passthrough_ff;
      if (csr_valid) begin
         case (csr_index)
            kbeq_pkg::CSR_BUFFER_BASE: base_in = csr_write_data;
            kbeq_pkg::CSR_QUEUE_SLOTS: slots_in = csr_write_data[15:0];
            kbeq_pkg::CSR_PASSTHROUGH: passthrough_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Ring limit follows the next configuration values
   assign limit_in = base_in + 32'(slots_in) * kbeq_pkg::RECORD_SIZE;

   // Configuration registers and ring limit
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff        <= '0;
         slots_ff       <= '0;
         passthrough_ff <= 1'b0;
         limit_ff       <= '0;
      end else begin
         base_ff        <= base_in;
         slots_ff       <= slots_in;
         passthrough_ff <= passthrough_in;
         limit_ff       <= limit_in;
      end
   end

   // Command reply
   always_comb begin
      model_cmd = 1'b0;
      case (command_byte)
         kbeq_pkg::CMD_INQUIRY, kbeq_pkg::CMD_INSTANT: reply = kbeq_pkg::REPLY_KEY;
         kbeq_pkg::CMD_TEST:  reply = kbeq_pkg::REPLY_TEST;
         kbeq_pkg::CMD_MODEL: begin
            reply     = kbeq_pkg::REPLY_MODEL;
            model_cmd = 1'b1;
         end
         default: reply = kbeq_pkg::REPLY_NONE;
      endcase
   end

   // Sticky enable, set by the model command
   assign enabled_in = enabled_ff |
                       (accept && (operation == kbeq_pkg::OP_COMMAND) && model_cmd);

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else begin
         enabled_ff <= enabled_in;
      end
   end

   // Key message and modifiers
   assign ch   = key_value[6:0];
   assign scan = kbeq_pkg::SCAN_ROM[ch];
   assign kind = {1'b0, operation} + 3'd2;

   always_comb begin
      if (passthrough_ff) begin
         msg  = key_value;
         mods = {3'b000, key_modifiers, 8'h00};
      end else begin
         msg = {1'b0, scan[6:0], 1'b0, ch};
         if (scan[7]) begin
            mods = kbeq_pkg::SHIFT_MOD;
         end else if (operation == kbeq_pkg::OP_KEY_DOWN) begin
            mods = {3'b000, key_modifiers, 8'h00};
         end else begin
            mods = '0;
         end
      end
   end

   // Place the new record and check for a full ring
   assign head_zero  = (queue_head == '0);
   assign next_rec   = queue_tail + kbeq_pkg::RECORD_SIZE;
   assign rec        = head_zero ? base_ff :
                       ((next_rec == limit_ff) ? base_ff : next_rec);
   assign ring_full  = !head_zero && (rec == queue_head);
   assign keep_event = enabled_ff && event_mask[{1'b0, kind}] && !ring_full;

   // Hand the classified item to the back end; drop filtered events
   assign desc_push = accept && ((operation == kbeq_pkg::OP_COMMAND) || keep_event);

   always_comb begin
      desc.is_cmd    = (operation == kbeq_pkg::OP_COMMAND);
      desc.reply     = reply;
      desc.link_addr = head_zero ? kbeq_pkg::HEAD_PTR_ADDR : queue_tail;
      desc.rec       = rec;
      desc.kind      = kind;
      desc.msg       = msg;
      desc.ticks     = tick_count;
      desc.where     = mouse_where;
      desc.mods      = mods;
   end

endmodule

// ----- rtl/core/kbeq_fifo.sv -----
// ---------------------------------------------------------------------------
// kbeq_fifo: descriptor queue between front and back
// A short first-in first-out buffer that lets each side stall on its own.
// ---------------------------------------------------------------------------
module kbeq_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  kbeq_pkg::desc_type    wr_data,
   output logic                  full,
   input  logic                  rd_en,
   output kbeq_pkg::desc_type    rd_data,
   output logic                  empty
);

   kbeq_pkg::desc_type                  mem_ff [kbeq_pkg::FIFO_DEPTH];
   logic [kbeq_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff;
   logic [kbeq_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff;
   logic [kbeq_pkg::FIFO_CNT_W-1:0]     count_ff;
   logic [kbeq_pkg::FIFO_CNT_W-1:0]     count_in;
   logic                                do_wr;
   logic                                do_rd;

   assign full    = (count_ff == kbeq_pkg::FIFO_CNT_W'(kbeq_pkg::FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Store incoming descriptors
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Track fill level
   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/kbeq_back.sv -----
// ---------------------------------------------------------------------------
// kbeq_back: carry out classified items
// Steps through a posted event's record writes, one per cycle unless held
// by pop, or emits a single command reply, into a registered result stage.
// ---------------------------------------------------------------------------
module kbeq_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  desc_empty,
   input  kbeq_pkg::desc_type    desc,
   output logic                  desc_pop,
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_result_kind,
   output logic [7:0]            rsp_reply_byte,
   output logic [31:0]           rsp_write_address,
   output logic [31:0]           rsp_write_data,
   output logic                  rsp_write_long,
   output logic                  rsp_last_item
);

   logic [kbeq_pkg::STEP_W-1:0] step_ff;
   logic                        valid_ff;
   logic                        load;
   logic                        last;
   logic [31:0]                 offset;

   logic        kind_in;
   logic [7:0]  reply_in;
   logic [31:0] addr_in;
   logic [31:0] data_in;
   logic        long_in;

   logic        kind_ff;
   logic [7:0]  reply_ff;
   logic [31:0] addr_ff;
   logic [31:0] data_ff;
   logic        long_ff;
   logic        last_ff;

   // Load the result stage when it is free or being drained
   assign load     = !desc_empty && (!valid_ff || pop);
   assign last     = desc.is_cmd || (step_ff == kbeq_pkg::STEP_MODS);
   assign desc_pop = load && last;

   // Record offset of each write step
   always_comb begin
      case (step_ff)
         kbeq_pkg::STEP_TYPE:  offset = kbeq_pkg::OFS_TYPE;
         kbeq_pkg::STEP_KIND:  offset = kbeq_pkg::OFS_KIND;
         kbeq_pkg::STEP_MSG:   offset = kbeq_pkg::OFS_MSG;
         kbeq_pkg::STEP_TICKS: offset = kbeq_pkg::OFS_TICKS;
         kbeq_pkg::STEP_WHERE: offset = kbeq_pkg::OFS_WHERE;
         kbeq_pkg::STEP_MODS:  offset = kbeq_pkg::OFS_MODS;
         default:              offset = '0;
      endcase
   end

   // Build the next result
   always_comb begin
      kind_in  = kbeq_pkg::RESULT_WRITE;
      reply_in = '0;
      addr_in  = desc.rec + offset;
      data_in  = '0;
      long_in  = 1'b1;
      if (desc.is_cmd) begin
         kind_in  = kbeq_pkg::RESULT_REPLY;
         reply_in = desc.reply;
         addr_in  = '0;
         long_in  = 1'b0;
      end else begin
         case (step_ff)
            kbeq_pkg::STEP_LINK: begin
               addr_in = desc.link_addr;
               data_in = desc.rec;
            end
            kbeq_pkg::STEP_TAIL: begin
               addr_in = kbeq_pkg::TAIL_PTR_ADDR;
               data_in = desc.rec;
            end
            kbeq_pkg::STEP_NEXT:  data_in = '0;
            kbeq_pkg::STEP_TYPE: begin
               data_in = {16'h0000, kbeq_pkg::EVENT_TYPE};
               long_in = 1'b0;
            end
            kbeq_pkg::STEP_KIND: begin
               data_in = {29'd0, desc.kind};
               long_in = 1'b0;
            end
            kbeq_pkg::STEP_MSG:   data_in = {16'h0000, desc.msg};
            kbeq_pkg::STEP_TICKS: data_in = desc.ticks;
            kbeq_pkg::STEP_WHERE: data_in = desc.where;
            kbeq_pkg::STEP_MODS: begin
               data_in = {16'h0000, desc.mods};
               long_in = 1'b0;
            end
            default: data_in = '0;
         endcase
      end
   end

   // Sequencer and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= kbeq_pkg::STEP_LINK;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            step_ff  <= last ? kbeq_pkg::STEP_LINK : step_ff + 1'b1;
         end else if (pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Hold result payload until transfer
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         reply_ff <= reply_in;
         addr_ff  <= addr_in;
         data_ff  <= data_in;
         long_ff  <= long_in;
         last_ff  <= last;
      end
   end

   assign empty             = !valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_reply_byte    = reply_ff;
   assign rsp_write_address = addr_ff;
   assign rsp_write_data    = data_ff;
   assign rsp_write_long    = long_ff;
   assign rsp_last_item     = last_ff;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: keyboard_event_queue_poster verification
// Drives command bytes and key events through the push/full queue port,
// predicts every reply and ring memory write in step with the accepted
// items, and compares each popped result field by field. Directed tests
// cover the command set, scan mapping, ring wrap and full cases and
// passthrough, then random traffic runs under several idle and stall mixes
// and a long receiver hold-off that backs the block up.
// ---------------------------------------------------------------------------
module testbench;

   // Record layout and pointer addresses, from the block specification
   localparam logic [31:0] REC_BYTES    = 32'd22;
   localparam logic [31:0] HEAD_POINTER = 32'h0000_014C;
   localparam logic [31:0] TAIL_POINTER = 32'h0000_0150;
   localparam logic [15:0] EVENT_WORD   = 16'h0004;
   localparam logic [15:0] SHIFT_BITS   = 16'h0200;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned TIMEOUT_NS    = 2_000_000;
   localparam int unsigned PRINT_CAP     = 60;

   // Character to scan code; bit 7 forces the shift modifier
   localparam logic [7:0] KEY_SCAN [0:127] = '{
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'h33, 8'h30, 8'hFF, 8'hFF, 8'hFF, 8'h49, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h46, 8'h42, 8'h4D, 8'h48,
      8'h31, 8'h92, 8'hA7, 8'h94, 8'h95, 8'h97, 8'h9A, 8'h27,
      8'h99, 8'h9D, 8'h9C, 8'h98, 8'h2B, 8'h1B, 8'h2F, 8'h2C,
      8'h1D, 8'h12, 8'h13, 8'h14, 8'h15, 8'h17, 8'h16, 8'h1A,
      8'h1C, 8'h19, 8'hA9, 8'h29, 8'hAB, 8'h18, 8'hAF, 8'hAC,
      8'h93, 8'h80, 8'h8B, 8'h88, 8'h82, 8'h8E, 8'h83, 8'h85,
      8'h84, 8'hA2, 8'hA6, 8'hA8, 8'hA5, 8'hAE, 8'hAD, 8'h9F,
      8'hA3, 8'h8C, 8'h8F, 8'h81, 8'h91, 8'hA0, 8'h89, 8'h8D,
      8'h87, 8'h90, 8'h86, 8'hFF, 8'h2A, 8'hFF, 8'h96, 8'h9B,
      8'h32, 8'h00, 8'h0B, 8'h08, 8'h02, 8'h0E, 8'h03, 8'h05,
      8'h04, 8'h22, 8'h26, 8'h28, 8'h25, 8'h2E, 8'h2D, 8'h1F,
      8'h23, 8'h0C, 8'h0F, 8'h01, 8'h11, 8'h20, 8'h09, 8'h0D,
      8'h07, 8'h10, 8'h06, 8'hFF, 8'hAA, 8'hFF, 8'hB2, 8'hFF
   };

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  command_byte;
      logic [15:0] key_value;
      logic [4:0]  key_modifiers;
      logic [15:0] event_mask;
      logic [31:0] queue_head;
      logic [31:0] queue_tail;
      logic [31:0] tick_count;
      logic [31:0] mouse_where;
   } key_item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  reply;
      logic [31:0] addr;
      logic [31:0] data;
      logic        wlong;
      logic        last;
   } poster_out_type;

   // DUT signals
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = kbeq_pkg::CSR_BUFFER_BASE;
   logic [31:0] csr_write_data = '0;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_operation = kbeq_pkg::OP_COMMAND;
   logic [7:0]  req_command_byte = '0;
   logic [15:0] req_key_value = '0;
   logic [4:0]  req_key_modifiers = '0;
   logic [15:0] req_event_mask = '0;
   logic [31:0] req_queue_head = '0;
   logic [31:0] req_queue_tail = '0;
   logic [31:0] req_tick_count = '0;
   logic [31:0] req_mouse_where = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_reply_byte;
   logic [31:0] rsp_write_address;
   logic [31:0] rsp_write_data;
   logic        rsp_write_long;
   logic        rsp_last_item;

   // Predictor state: register copies and the sticky enable
   logic [31:0] cfg_base = '0;
   logic [15:0] cfg_slots = '0;
   logic        cfg_passthrough = 1'b0;
   logic        events_enabled = 1'b0;

   poster_out_type awaited_results[$];
   int unsigned mismatch_count = 0;
   int unsigned popped_count = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_cycles = 0;

   keyboard_event_queue_poster u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .push              (push),
      .full              (full),
      .req_operation     (req_operation),
      .req_command_byte  (req_command_byte),
      .req_key_value     (req_key_value),
      .req_key_modifiers (req_key_modifiers),
      .req_event_mask    (req_event_mask),
      .req_queue_head    (req_queue_head),
      .req_queue_tail    (req_queue_tail),
      .req_tick_count    (req_tick_count),
      .req_mouse_where   (req_mouse_where),
      .empty             (empty),
      .pop               (pop),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_write_long    (rsp_write_long),
      .rsp_last_item     (rsp_last_item)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   // Queue one memory write; word writes keep only the low 16 bits
   function automatic void add_write(input logic [31:0] addr, input logic [31:0] data,
                                     input logic is_long);
      poster_out_type r;
      r.kind  = kbeq_pkg::RESULT_WRITE;
      r.reply = kbeq_pkg::REPLY_NONE;
      r.addr  = addr;
      r.data  = is_long ? data : {16'h0000, data[15:0]};
      r.wlong = is_long;
      r.last  = 1'b0;
      awaited_results.push_back(r);
   endfunction

   // Work out the reply or the ring writes that one accepted item causes
   function automatic void derive_results(input key_item_type it);
      poster_out_type r;
      logic [2:0]  kind;
      logic [6:0]  ch;
      logic [7:0]  scan;
      logic [15:0] msg;
      logic [15:0] mods;
      logic [31:0] rec;
      logic [31:0] limit;
      if (it.operation == kbeq_pkg::OP_COMMAND) begin
         r = '0;
         r.kind = kbeq_pkg::RESULT_REPLY;
         r.last = 1'b1;
         case (it.command_byte)
            kbeq_pkg::CMD_INQUIRY, kbeq_pkg::CMD_INSTANT: r.reply = kbeq_pkg::REPLY_KEY;
            kbeq_pkg::CMD_TEST: r.reply = kbeq_pkg::REPLY_TEST;
            kbeq_pkg::CMD_MODEL: begin
               r.reply = kbeq_pkg::REPLY_MODEL;
               events_enabled = 1'b1;
            end
            default: r.reply = kbeq_pkg::REPLY_NONE;
         endcase
         awaited_results.push_back(r);
         return;
      end

      kind = {1'b0, it.operation} + 3'd2;
      if (cfg_passthrough) begin
         msg  = it.key_value;
         mods = {3'b000, it.key_modifiers, 8'h00};
      end else begin
         ch   = it.key_value[6:0];
         scan = KEY_SCAN[ch];
         mods = (it.operation == kbeq_pkg::OP_KEY_DOWN) ?
                {3'b000, it.key_modifiers, 8'h00} : 16'h0000;
         if (scan[7]) begin
            mods = SHIFT_BITS;
         end
         msg = {1'b0, scan[6:0], 1'b0, ch};
      end

      // Drop when disabled or masked off
      if (!events_enabled || !it.event_mask[kind]) return;

      limit = cfg_base + {16'h0000, cfg_slots} * REC_BYTES;
      if (it.queue_head == 32'h0) begin
         rec = cfg_base;
         add_write(HEAD_POINTER, rec, 1'b1);
      end else begin
         rec = it.queue_tail + REC_BYTES;
         if (rec == limit) rec = cfg_base;
         // Drop when the ring is full
         if (rec == it.queue_head) return;
         add_write(it.queue_tail, rec, 1'b1);
      end
      add_write(TAIL_POINTER, rec, 1'b1);
      add_write(rec, 32'h0, 1'b1);
      add_write(rec + 32'd4, {16'h0000, EVENT_WORD}, 1'b0);
      add_write(rec + 32'd6, {29'h0, kind}, 1'b0);
      add_write(rec + 32'd8, {16'h0000, msg}, 1'b1);
      add_write(rec + 32'd12, it.tick_count, 1'b1);
      add_write(rec + 32'd16, it.mouse_where, 1'b1);
      add_write(rec + 32'd20, {16'h0000, mods}, 1'b0);
      awaited_results[awaited_results.size() - 1].last = 1'b1;
   endfunction

   // Drive pop: long hold-off first, then random stalls
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Compare each popped result with the oldest prediction
   always @(posedge clock) begin : check_results
      poster_out_type want;
      if (!reset && pop && !empty) begin
         popped_count++;
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none awaited", popped_count));
         end else begin
            want = awaited_results.pop_front();
            if (rsp_result_kind !== want.kind)
               report_mismatch($sformatf("result %0d kind %0b, want %0b",
                                         popped_count, rsp_result_kind, want.kind));
            if (rsp_reply_byte !== want.reply)
               report_mismatch($sformatf("result %0d reply %h, want %h",
                                         popped_count, rsp_reply_byte, want.reply));
            if (rsp_write_address !== want.addr)
               report_mismatch($sformatf("result %0d address %h, want %h",
                                         popped_count, rsp_write_address, want.addr));
            if (rsp_write_data !== want.data)
               report_mismatch($sformatf("result %0d data %h, want %h",
                                         popped_count, rsp_write_data, want.data));
            if (rsp_write_long !== want.wlong)
               report_mismatch($sformatf("result %0d long %0b, want %0b",
                                         popped_count, rsp_write_long, want.wlong));
            if (rsp_last_item !== want.last)
               report_mismatch($sformatf("result %0d last %0b, want %0b",
                                         popped_count, rsp_last_item, want.last));
         end
      end
   end

   // Offer one item, with random idle cycles first, and predict on transfer
   task automatic send_item(input key_item_type it);
      while ($urandom_range(99) < sender_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push              <= 1'b1;
      req_operation     <= it.operation;
      req_command_byte  <= it.command_byte;
      req_key_value     <= it.key_value;
      req_key_modifiers <= it.key_modifiers;
      req_event_mask    <= it.event_mask;
      req_queue_head    <= it.queue_head;
      req_queue_tail    <= it.queue_tail;
      req_tick_count    <= it.tick_count;
      req_mouse_where   <= it.mouse_where;
      @(posedge clock);
      while (full) @(posedge clock);
      derive_results(it);
   endtask

   task automatic release_input();
      push <= 1'b0;
   endtask

   // Wait for every awaited result, then let dropped items clear the pipe
   task automatic drain_and_pause();
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr_valid      <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         kbeq_pkg::CSR_BUFFER_BASE: cfg_base = value;
         kbeq_pkg::CSR_QUEUE_SLOTS: cfg_slots = value[15:0];
         kbeq_pkg::CSR_PASSTHROUGH: cfg_passthrough = value[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_ring(input logic [31:0] base, input logic [31:0] slots,
                                 input logic [31:0] passthrough);
      drain_and_pause();
      write_register(kbeq_pkg::CSR_BUFFER_BASE, base);
      write_register(kbeq_pkg::CSR_QUEUE_SLOTS, slots);
      write_register(kbeq_pkg::CSR_PASSTHROUGH, passthrough);
   endtask

   function automatic key_item_type make_key(input logic [1:0] op, input logic [15:0] key,
                                             input logic [4:0] mods, input logic [15:0] mask,
                                             input logic [31:0] head, input logic [31:0] tail);
      key_item_type it;
      it.operation     = op;
      it.command_byte  = 8'($urandom);
      it.key_value     = key;
      it.key_modifiers = mods;
      it.event_mask    = mask;
      it.queue_head    = head;
      it.queue_tail    = tail;
      it.tick_count    = $urandom;
      it.mouse_where   = $urandom;
      return it;
   endfunction

   // Command item with random noise in the unused fields
   function automatic key_item_type make_command(input logic [7:0] code);
      key_item_type it;
      it = make_key(kbeq_pkg::OP_COMMAND, 16'($urandom), 5'($urandom), 16'($urandom),
                    $urandom, $urandom);
      it.command_byte = code;
      return it;
   endfunction

   // Some commands; else mostly well-formed ring positions, some full rings, some raw noise
   function automatic key_item_type random_item();
      key_item_type it;
      int unsigned  ring;
      int unsigned  tail_slot;
      int unsigned  head_slot;
      int unsigned  shape;
      if ($urandom_range(99) < 12) begin
         if ($urandom_range(1) == 0) begin
            case ($urandom_range(3))
               0: it = make_command(kbeq_pkg::CMD_INQUIRY);
               1: it = make_command(kbeq_pkg::CMD_INSTANT);
               2: it = make_command(kbeq_pkg::CMD_MODEL);
               default: it = make_command(kbeq_pkg::CMD_TEST);
            endcase
         end else begin
            it = make_command(8'($urandom));
         end
         return it;
      end
      it = make_key(2'($urandom_range(3, 1)), 16'($urandom), 5'($urandom),
                    16'($urandom), $urandom, $urandom);
      if ($urandom_range(99) < 85) it.event_mask[5:3] = 3'b111;
      ring      = (cfg_slots == 0) ? 1 : cfg_slots;
      tail_slot = $urandom_range(ring - 1);
      head_slot = ($urandom_range(99) < 20) ? (tail_slot + 1) % ring : $urandom_range(ring - 1);
      shape     = $urandom_range(99);
      if (shape < 20) begin
         it.queue_head = 32'h0;
      end else if (shape < 85) begin
         it.queue_tail = cfg_base + tail_slot * REC_BYTES;
         it.queue_head = cfg_base + head_slot * REC_BYTES;
      end
      return it;
   endfunction

   // Replies to every command class; events before enable are dropped
   task automatic test_command_replies();
      send_item(make_key(kbeq_pkg::OP_KEY_DOWN, 16'h0061, 5'h1F, 16'hFFFF, 32'h0, 32'h0));
      send_item(make_command(kbeq_pkg::CMD_INQUIRY));
      send_item(make_command(kbeq_pkg::CMD_INSTANT));
      send_item(make_command(kbeq_pkg::CMD_TEST));
      send_item(make_command(8'h00));
      send_item(make_command(8'hFF));
      send_item(make_command(kbeq_pkg::CMD_MODEL));
      send_item(make_command(kbeq_pkg::CMD_MODEL));
      release_input();
   endtask

   // Scan mapping, shift forcing, unmapped characters and mask gating
   task automatic test_key_mapping();
      configure_ring(32'h0000_1000, 32'd8, 32'd0);
      send_item(make_key(kbeq_pkg::OP_KEY_DOWN, 16'h0061, 5'h1F, 16'hFFFF, 32'h0, 32'h0));
      send_item(make_key(kbeq_pkg::OP_KEY_UP, 16'hFFFF, 5'h1F, 16'hFFFF, 32'h0, 32'h0));
      send_item(make_key(kbeq_pkg::OP_KEY_AUTO, 16'h0041, 5'h00, 16'hFFFF, 32'h0, 32'h0));
      send_item(make_key(kbeq_pkg::OP_KEY_DOWN, 16'h0000, 5'h1F, 16'h0008, 32'h0, 32'h0));
      send_item(make_key(kbeq_pkg::OP_KEY_DOWN, 16'h0031, 5'h01, 16'hFFF7, 32'h0, 32'h0));
      send_item(make_key(kbeq_pkg::OP_KEY_UP, 16'h8020, 5'h10, 16'h0010, 32'h0, 32'h0));
      send_item(make_key(kbeq_pkg::OP_KEY_AUTO, 16'h0031, 5'h1F, 16'h0000, 32'h0, 32'h0));
      release_input();
   endtask

   // Append, full ring, wrap to base, full after wrap, 32-bit address wrap
   task automatic test_ring_cases();
      send_item(make_key(kbeq_pkg::OP_KEY_DOWN, 16'h0062, 5'h05, 16'hFFFF,
                         cfg_base + 3 * REC_BYTES, cfg_base));
      send_item(make_key(kbeq_pkg::OP_KEY_DOWN, 16'h0062, 5'h05, 16'hFFFF,
                         cfg_base + 2 * REC_BYTES, cfg_base + REC_BYTES));
      send_item(make_key(kbeq_pkg::OP_KEY_UP, 16'h0063, 5'h00, 16'hFFFF,
                         cfg_base + REC_BYTES, cfg_base + 7 * REC_BYTES));
      send_item(make_key(kbeq_pkg::OP_KEY_UP, 16'h0063, 5'h00, 16'hFFFF,
                         cfg_base, cfg_base + 7 * REC_BYTES));
      send_item(make_key(kbeq_pkg::OP_KEY_AUTO, 16'h007A, 5'h00, 16'hFFFF,
                         32'h0000_0012, 32'hFFFF_FFF0));
      release_input();
   endtask

   // Raw key word and modifiers bypass the scan table
   task automatic test_passthrough();
      configure_ring(32'h0000_1000, 32'd8, 32'd1);
      send_item(make_key(kbeq_pkg::OP_KEY_DOWN, 16'hFFFF, 5'h1F, 16'hFFFF, 32'h0, 32'h0));
      send_item(make_key(kbeq_pkg::OP_KEY_UP, 16'h8000, 5'h10, 16'hFFFF, 32'h0, 32'h0));
      send_item(make_key(kbeq_pkg::OP_KEY_AUTO, 16'h0000, 5'h00, 16'hFFFF, 32'h0, 32'h0));
      release_input();
   endtask

   task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned count, input logic [31:0] base,
                                      input logic [31:0] slots, input logic [31:0] passthrough);
      configure_ring(base, slots, passthrough);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) send_item(random_item());
      release_input();
   endtask

   // Hold the receiver off while events keep coming, so the input stalls
   task automatic test_backpressure();
      configure_ring(32'h0000_2000, 32'd64, 32'd0);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_cycles        = 400;
      repeat (30) begin
         send_item(make_key(2'($urandom_range(3, 1)), 16'($urandom), 5'($urandom),
                            16'hFFFF, 32'h0, $urandom));
      end
      release_input();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_register(kbeq_pkg::CSR_BUFFER_BASE, 32'h0);
      write_register(kbeq_pkg::CSR_QUEUE_SLOTS, 32'h0);
      write_register(kbeq_pkg::CSR_PASSTHROUGH, 32'h0);

      test_command_replies();
      test_key_mapping();
      test_ring_cases();
      test_passthrough();
      test_random_traffic(0, 0, 105, 32'h0000_1000, 32'd5, 32'd0);
      test_random_traffic(51, 0, 105, 32'hFFFF_FFFF, 32'd65535, 32'd1);
      test_random_traffic(0, 51, 105, 32'h0, 32'h0, 32'd0);
      test_random_traffic(19, 19, 105, $urandom, 32'hFFFF_0003, 32'($urandom_range(1)));
      test_backpressure();

      drain_and_pause();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/kbeq_pkg.sv
rtl/core/kbeq_front.sv
rtl/core/kbeq_fifo.sv
rtl/core/kbeq_back.sv
rtl/core/keyboard_event_queue_poster.sv
test/testbench.sv
